/* sv/slm_pkg.sv */
package slm_pkg;

   // list storage
   localparam int LIST_DEPTH = 32;
   localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int TOTAL_W    = $clog2(2 * LIST_DEPTH + 1);

   // payload widths
   localparam int DATA_W = 32;
   localparam int MODE_W = 2;

   // request selector carried in tuser
   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD_FIRST  = 2'd0,
      MODE_LOAD_SECOND = 2'd1,
      MODE_MERGE       = 2'd2
   } mode_type;

   // merge sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_PICK
   } state_type;

endpackage

/* sv/slm_ram.sv */
module slm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/sorted_list_merge.sv */
// Two-way merge of two ascending lists of signed 32-bit values.
//
// Request channel (req_*): req_tuser selects the operation, req_tdata
// carries the value. Load first list and load second list append
// req_tdata to that list; loads into a full list are dropped. A merge
// transaction streams the merged ascending sequence on the response
// channel (rsp_*), one value per transaction, with rsp_tlast
// on the final one. On equal heads the second list's head goes out first.
// A merge with both lists empty produces no response. Selector code 3
// is accepted and ignored. Both lists are empty again after a merge.
//
// Sequence: the merge transaction is taken in ST_IDLE, then each result
// passes through ST_READ, for the list RAM read register, and then
// ST_PICK, for the shared head comparator and output load. req_tready
// is low while a merge runs. The response register holds its
// transaction while rsp_tready is low and the sequencer waits; loads
// are taken while the last result is still pending.
//
// Reset (synchronous, active high) empties both lists and the response
// register; list RAM contents are not cleared and are never read unwritten.
module sorted_list_merge (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [slm_pkg::DATA_W-1:0]  req_tdata,   // [31:0] value
   input  logic [slm_pkg::MODE_W-1:0]  req_tuser,   // [1:0] mode
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [slm_pkg::DATA_W-1:0]  rsp_tdata,   // [31:0] merged_value
   output logic                        rsp_tlast    // last
);

   import slm_pkg::*;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   first_cnt_ff, first_cnt_in;
   logic [CNT_W-1:0]   second_cnt_ff, second_cnt_in;
   logic [CNT_W-1:0]   first_idx_ff, first_idx_in;
   logic [CNT_W-1:0]   second_idx_ff, second_idx_in;
   logic [TOTAL_W-1:0] remain_ff, remain_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               first_we, second_we;
   logic [DATA_W-1:0]  first_rd, second_rd;
   logic [TOTAL_W-1:0] total;
   logic               take_first;

   // list storage
   slm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_first_ram (
      .clock   (clock),
      .wr_en   (first_we),
      .wr_addr (first_cnt_ff[ADDR_W-1:0]),
      .wr_data (req_tdata),
      .rd_addr (first_idx_ff[ADDR_W-1:0]),
      .rd_data (first_rd)
   );

   slm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_second_ram (
      .clock   (clock),
      .wr_en   (second_we),
      .wr_addr (second_cnt_ff[ADDR_W-1:0]),
      .wr_data (req_tdata),
      .rd_addr (second_idx_ff[ADDR_W-1:0]),
      .rd_data (second_rd)
   );

   assign total = TOTAL_W'(first_cnt_ff) + TOTAL_W'(second_cnt_ff);

   // shared head compare: first list wins when strictly smaller or when the second list is exhausted
   assign take_first = (first_idx_ff != first_cnt_ff) &&
                       ((second_idx_ff == second_cnt_ff) ||
                        ($signed(first_rd) < $signed(second_rd)));

   // sequencer next state and datapath control
   always_comb begin
      state_in      = state_ff;
      first_cnt_in  = first_cnt_ff;
      second_cnt_in = second_cnt_ff;
      first_idx_in  = first_idx_ff;
      second_idx_in = second_idx_ff;
      remain_in     = remain_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      first_we      = 1'b0;
      second_we     = 1'b0;
      req_tready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (mode_type'(req_tuser))
                  MODE_LOAD_FIRST: begin
                     if (first_cnt_ff != CNT_W'(LIST_DEPTH)) begin
                        first_we     = 1'b1;
                        first_cnt_in = first_cnt_ff + CNT_W'(1);
                     end
                  end
                  MODE_LOAD_SECOND: begin
                     if (second_cnt_ff != CNT_W'(LIST_DEPTH)) begin
                        second_we     = 1'b1;
                        second_cnt_in = second_cnt_ff + CNT_W'(1);
                     end
                  end
                  MODE_MERGE: begin
                     if (total != '0) begin
                        state_in      = ST_READ;
                        first_idx_in  = '0;
                        second_idx_in = '0;
                        remain_in     = total;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            // heads are in the RAM read registers next cycle
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = (remain_ff == TOTAL_W'(1));
               remain_in    = remain_ff - TOTAL_W'(1);
               if (take_first) begin
                  rsp_data_in  = first_rd;
                  first_idx_in = first_idx_ff + CNT_W'(1);
               end else begin
                  rsp_data_in   = second_rd;
                  second_idx_in = second_idx_ff + CNT_W'(1);
               end
               if (remain_ff == TOTAL_W'(1)) begin
                  state_in      = ST_IDLE;
                  first_cnt_in  = '0;
                  second_cnt_in = '0;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         first_cnt_ff  <= '0;
         second_cnt_ff <= '0;
         first_idx_ff  <= '0;
         second_idx_ff <= '0;
         remain_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_cnt_ff  <= first_cnt_in;
         second_cnt_ff <= second_cnt_in;
         first_idx_ff  <= first_idx_in;
         second_idx_ff <= second_idx_in;
         remain_ff     <= remain_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* sv/slm_checker.sv */
module slm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic [slm_pkg::MODE_W-1:0]  req_tuser,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [slm_pkg::DATA_W-1:0]  rsp_tdata,
   input logic                        rsp_tlast
);

   import slm_pkg::*;

   // stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // no request taken while a merge run is still being delivered
   a_busy_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request ready in the middle of a merge run");

   // a load never creates a response
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != MODE_MERGE) && !rsp_tvalid
         |=> !rsp_tvalid)
      else $error("response appeared after a load");

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind sorted_list_merge slm_checker u_slm_checker (.*);

/* tb/tb_sorted_list_merge.sv */
`timescale 1ns / 100ps

import slm_pkg::*;

// one merged output beat as the block should present it
typedef struct packed {
   logic [DATA_W-1:0] value;
   logic              last;
} merged_beat_type;

// Scoreboard: keeps its own copy of both lists, expands every merge
// into the ascending beats it must produce, and checks them in order.
class merge_scoreboard;
   logic [DATA_W-1:0] first_vals  [LIST_DEPTH];
   logic [DATA_W-1:0] second_vals [LIST_DEPTH];
   int                first_len;
   int                second_len;
   merged_beat_type   expected_q [$];
   int                fault_count;

   function new();
      first_len   = 0;
      second_len  = 0;
      fault_count = 0;
   endfunction

   function void flag_fault(string what, merged_beat_type exp_beat, merged_beat_type got_beat);
      fault_count++;
      if (fault_count <= 10) begin
         $display("[%0t] %s: expected value %h last %b, got value %h last %b",
                  $time, what, exp_beat.value, exp_beat.last, got_beat.value, got_beat.last);
      end
   endfunction

   // accepted request transaction
   function void note_request(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] value);
      int              i;
      int              j;
      logic            take_first;
      merged_beat_type beat;
      case (mode)
         MODE_LOAD_FIRST: begin
            // loads into a full list are dropped
            if (first_len < LIST_DEPTH) begin
               first_vals[first_len] = value;
               first_len++;
            end
         end
         MODE_LOAD_SECOND: begin
            if (second_len < LIST_DEPTH) begin
               second_vals[second_len] = value;
               second_len++;
            end
         end
         MODE_MERGE: begin
            i = 0;
            j = 0;
            while (i < first_len || j < second_len) begin
               // strict compare: equal heads let the second list go first
               if (i < first_len && j < second_len)
                  take_first = $signed(first_vals[i]) < $signed(second_vals[j]);
               else
                  take_first = (i < first_len);
               if (take_first) begin
                  beat.value = first_vals[i];
                  i++;
               end else begin
                  beat.value = second_vals[j];
                  j++;
               end
               beat.last = (i == first_len) && (j == second_len);
               expected_q.push_back(beat);
            end
            first_len  = 0;
            second_len = 0;
         end
         default: ;
      endcase
   endfunction

   // accepted response transaction
   function void check_result(logic [DATA_W-1:0] value, logic last);
      merged_beat_type got_beat;
      merged_beat_type exp_beat;
      got_beat.value = value;
      got_beat.last  = last;
      if (expected_q.size() == 0) begin
         exp_beat = '0;
         flag_fault("unexpected response", exp_beat, got_beat);
      end else begin
         exp_beat = expected_q.pop_front();
         if (exp_beat !== got_beat) flag_fault("response mismatch", exp_beat, got_beat);
      end
   endfunction
endclass

module tb_sorted_list_merge;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [DATA_W-1:0] VAL_MIN     = 32'h8000_0000;
   localparam logic [DATA_W-1:0] VAL_MAX     = 32'h7fff_ffff;
   localparam int                REQ_TARGET  = 210;

   // how the values of one load set are drawn
   typedef enum int {
      SET_WIDE,
      SET_NARROW,
      SET_UNSORTED
   } set_kind_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata;
   logic [MODE_W-1:0] req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [DATA_W-1:0] rsp_tdata;
   logic              rsp_tlast;

   merge_scoreboard sb;
   int              burst_left;
   int              req_count;
   int unsigned     stall_cycle = 0;

   sorted_list_merge dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // response side: check accepted beats, stall on a rotating pattern
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
      stall_cycle <= stall_cycle + 1;
      case (stall_cycle[8:7])
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= 1'($urandom_range(0, 1));
         2'd2:    rsp_tready <= (stall_cycle[2:0] != 3'd0);
         default: rsp_tready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // one request transaction; bursts of random length, random gaps between
   task send_item(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] value);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      sb.note_request(mode, value);
      burst_left--;
      if (mode != MODE_UNUSED) req_count++;
   endtask

   // load both lists in random interleave, then merge
   task merge_set(int n_first, int n_second, set_kind_type kind);
      int                left [2];
      longint            walk [2];
      int unsigned       step_max;
      int                sel;
      logic [DATA_W-1:0] v;
      left[0] = n_first;
      left[1] = n_second;
      for (int s = 0; s < 2; s++) begin
         if (kind == SET_NARROW)
            walk[s] = $signed($urandom_range(0, 16)) - 8;
         else if ($urandom_range(0, 3) == 0)
            walk[s] = -64'sd2147483648 + $urandom_range(0, 3);
         else
            walk[s] = $signed($urandom);
      end
      step_max = (kind == SET_NARROW) ? 2 : (32'd1 << $urandom_range(0, 28));
      while (left[0] + left[1] > 0) begin
         if (left[0] == 0)      sel = 1;
         else if (left[1] == 0) sel = 0;
         else                   sel = $urandom_range(0, 1);
         if (kind == SET_UNSORTED) begin
            v = $urandom;
         end else begin
            // ascending walk, pinned at the top of the signed range
            walk[sel] += $urandom_range(0, step_max);
            if (walk[sel] > 64'sd2147483647) walk[sel] = 64'sd2147483647;
            v = walk[sel][DATA_W-1:0];
         end
         send_item(sel ? MODE_LOAD_SECOND : MODE_LOAD_FIRST, v);
         left[sel]--;
         if ($urandom_range(0, 19) == 0) send_item(MODE_UNUSED, $urandom);
      end
      send_item(MODE_MERGE, $urandom);
   endtask

   initial begin
      int           set_index;
      int           n_first;
      int           n_second;
      int           roll;
      int           wait_cycles;
      set_kind_type kind;

      sb          = new();
      burst_left  = 0;
      req_count   = 0;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= MODE_LOAD_FIRST;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty merge, unused selector, extremes and equal heads
      send_item(MODE_MERGE, 32'h0);
      send_item(MODE_UNUSED, 32'hffff_ffff);
      send_item(MODE_LOAD_FIRST, VAL_MIN);
      send_item(MODE_LOAD_SECOND, VAL_MIN);
      send_item(MODE_LOAD_FIRST, 32'hffff_ffff);
      send_item(MODE_LOAD_SECOND, 32'h0);
      send_item(MODE_LOAD_FIRST, 32'h0);
      send_item(MODE_LOAD_SECOND, VAL_MAX);
      send_item(MODE_LOAD_FIRST, VAL_MAX);
      send_item(MODE_LOAD_SECOND, VAL_MAX);
      send_item(MODE_MERGE, 32'h0);
      // only the first list holds data
      send_item(MODE_LOAD_FIRST, 32'd1);
      send_item(MODE_LOAD_FIRST, 32'd2);
      send_item(MODE_LOAD_FIRST, 32'd3);
      send_item(MODE_MERGE, 32'h0);
      // only the second list holds data
      send_item(MODE_LOAD_SECOND, 32'hffff_fff0);
      send_item(MODE_LOAD_SECOND, 32'h0000_0010);
      send_item(MODE_MERGE, 32'h0);
      // unsorted first list, merged as stored
      send_item(MODE_LOAD_FIRST, 32'd5);
      send_item(MODE_LOAD_FIRST, 32'd1);
      send_item(MODE_LOAD_SECOND, 32'd3);
      send_item(MODE_MERGE, 32'h0);
      // one equal value on each side
      send_item(MODE_LOAD_FIRST, 32'd7);
      send_item(MODE_LOAD_SECOND, 32'd7);
      send_item(MODE_MERGE, 32'h0);

      // random: mostly small sorted sets, some duplicates, unsorted and full lists
      set_index = 0;
      while (req_count < REQ_TARGET) begin
         roll = $urandom_range(0, 9);
         if (roll < 5)      kind = SET_WIDE;
         else if (roll < 8) kind = SET_NARROW;
         else               kind = SET_UNSORTED;
         n_first  = $urandom_range(0, 8);
         n_second = $urandom_range(0, 8);
         if (set_index % 8 == 3) begin
            // fill one list to near or past its depth, or both
            if ($urandom_range(0, 1)) n_first = $urandom_range(LIST_DEPTH - 2, LIST_DEPTH + 4);
            else                      n_second = $urandom_range(LIST_DEPTH - 2, LIST_DEPTH + 4);
            if ($urandom_range(0, 3) == 0) n_first = LIST_DEPTH + 1;
         end
         merge_set(n_first, n_second, kind);
         set_index++;
      end
      req_tvalid <= 1'b0;

      // drain outstanding responses, then a short quiet period
      wait_cycles = 0;
      while (sb.expected_q.size() != 0 && wait_cycles < 4000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (sb.expected_q.size() != 0) begin
         $display("[%0t] %0d expected responses never arrived", $time, sb.expected_q.size());
         sb.fault_count++;
      end

      if (sb.fault_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* files.f */
sv/slm_pkg.sv
sv/slm_ram.sv
sv/sorted_list_merge.sv
sv/slm_checker.sv
tb/tb_sorted_list_merge.sv
